### design/radical_simplifier_defines.svh
// Assertion macros shared by the radical simplifier modules.
`ifndef RADICAL_SIMPLIFIER_DEFINES_SVH
`define RADICAL_SIMPLIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rs_pkg.sv
// Types and constants shared by the radical simplifier modules.
package rs_pkg;

    // Field widths of one input item and one result item.
    localparam int COEFF_IN_W = 16;
    localparam int IDX_W      = 5;
    localparam int RAD_IN_W   = 16;
    localparam int XP_W       = 8;
    localparam int COEFF_W    = 24;
    localparam int RAD_OUT_W  = 16;
    localparam int XOUT_W     = 7;
    localparam int XIN_W      = 4;

    // Packed bus widths, padded to whole bytes.
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    // Smallest legal root index and first trial divisor.
    localparam logic [IDX_W-1:0] IDX_MIN = 5'd2;
    localparam int               D_FIRST = 2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_XDIV,
        S_POW,
        S_CMP,
        S_DIV,
        S_APPLY,
        S_DONE
    } t_rs_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic xdiv_step;
        logic pow_init;
        logic pow_step;
        logic div_init;
        logic div_step;
        logic apply;
        logic out_load;
    } t_rs_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic xdiv_last;
        logic pow_last;
        logic div_last;
        logic p_gt_rad;
        logic rem_zero;
        logic invalid;
    } t_rs_status;

endpackage

### design/rs_dpath.sv
// Datapath: operand registers, power multiplier, shift-subtract dividers, result register.
`include "radical_simplifier_defines.svh"

module rs_dpath
    import rs_pkg::*;
#(
    parameter int RADICAND_BITS = 16,
    parameter int MAX_INDEX     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_rs_cmd                     i_cmd,
    output t_rs_status                  o_st,
    input  logic signed [COEFF_IN_W-1:0] i_coeff_in,
    input  logic [IDX_W-1:0]            i_root_index,
    input  logic [RAD_IN_W-1:0]         i_radicand_in,
    input  logic [XP_W-1:0]             i_x_power,
    output logic signed [COEFF_W-1:0]   o_coeff_out,
    output logic [RAD_OUT_W-1:0]        o_radicand_out,
    output logic [XOUT_W-1:0]           o_x_power_outside,
    output logic [XIN_W-1:0]            o_x_power_inside,
    output logic                        o_index_invalid
);

    localparam int RB     = RADICAND_BITS;
    localparam int PW     = RB + 1;
    localparam int DW     = (RB + 1) / 2 + 1;
    localparam int PROD_W = PW + DW;
    localparam int CNT_W  = $clog2(RB + 32);
    localparam logic [PW-1:0] CAP = {1'b1, {RB{1'b0}}};

    // Working registers.
    logic [COEFF_W-1:0] r_coeff;
    logic [IDX_W-1:0]   r_idx;
    logic [RB-1:0]      r_rad;
    logic [DW-1:0]      r_d;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_rem;
    logic [RB-1:0]      r_quo;
    logic [XP_W-1:0]    r_xq;
    logic [IDX_W-1:0]   r_xrem;
    logic [CNT_W-1:0]   r_cnt;

    // Result register.
    logic [COEFF_W-1:0]   r_res_coeff;
    logic [RAD_OUT_W-1:0] r_res_rad;
    logic [XOUT_W-1:0]    r_res_xout;
    logic [XIN_W-1:0]     r_res_xin;
    logic                 r_res_invalid;

    logic [PROD_W-1:0]  w_prod;
    logic [PW-1:0]      w_p_sat;
    logic [PW-1:0]      w_div_shift;
    logic               w_div_ge;
    logic [IDX_W:0]     w_x_shift;
    logic               w_x_ge;
    logic [COEFF_W-1:0] w_coeff_prod;
    logic               w_invalid;
    logic               w_rem_zero;

    // Next power: one multiply by d, saturated at the cap.
    assign w_prod  = PROD_W'(r_p) * PROD_W'(r_d);
    assign w_p_sat = (w_prod > PROD_W'(CAP)) ? CAP : w_prod[PW-1:0];

    // Radicand divider step: shift in the next dividend bit, subtract if it fits.
    assign w_div_shift = {r_rem[RB-1:0], r_quo[RB-1]};
    assign w_div_ge    = (w_div_shift >= r_p);

    // Exponent divider step, same scheme on the narrow values.
    assign w_x_shift = {r_xrem, r_xq[XP_W-1]};
    assign w_x_ge    = (w_x_shift >= {1'b0, r_idx});

    // Coefficient times the extracted factor, wrapping at the result width.
    assign w_coeff_prod = r_coeff * COEFF_W'(r_d);

    assign w_invalid  = (r_idx < IDX_MIN) || (r_idx > IDX_W'(MAX_INDEX));
    assign w_rem_zero = (r_rem == '0);

    // Status toward the controller.
    always_comb begin
        o_st.xdiv_last = (r_cnt == CNT_W'(XP_W - 1));
        o_st.pow_last  = (r_cnt == CNT_W'(r_idx - 5'd1));
        o_st.div_last  = (r_cnt == CNT_W'(RB - 1));
        o_st.p_gt_rad  = (r_p > PW'(r_rad));
        o_st.rem_zero  = w_rem_zero;
        o_st.invalid   = w_invalid;
    end

    // Step counter shared by the three iterative phases.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.pow_init || i_cmd.div_init) begin
            r_cnt <= '0;
        end else if (i_cmd.xdiv_step || i_cmd.pow_step || i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Operand capture, factor removal and divisor advance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coeff <= COEFF_W'(i_coeff_in);
            r_idx   <= i_root_index;
            r_rad   <= RB'(i_radicand_in);
            r_d     <= DW'(D_FIRST);
        end else if (i_cmd.apply) begin
            if (w_rem_zero) begin
                r_rad   <= r_quo;
                r_coeff <= w_coeff_prod;
            end else begin
                r_d <= r_d + 1'b1;
            end
        end
    end

    // Power of the trial divisor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_init) begin
            r_p <= PW'(1);
        end else if (i_cmd.pow_step) begin
            r_p <= w_p_sat;
        end
    end

    // Radicand divided by the power.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_rad;
        end else if (i_cmd.div_step) begin
            r_rem <= w_div_ge ? (w_div_shift - r_p) : w_div_shift;
            r_quo <= {r_quo[RB-2:0], w_div_ge};
        end
    end

    // Exponent of x divided by the index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xq   <= i_x_power;
            r_xrem <= '0;
        end else if (i_cmd.xdiv_step) begin
            r_xrem <= IDX_W'(w_x_ge ? (w_x_shift - {1'b0, r_idx}) : w_x_shift);
            r_xq   <= {r_xq[XP_W-2:0], w_x_ge};
        end
    end

    // Result register; an invalid index clears every field but the flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_invalid <= w_invalid;
            if (w_invalid) begin
                r_res_coeff <= '0;
                r_res_rad   <= '0;
                r_res_xout  <= '0;
                r_res_xin   <= '0;
            end else begin
                r_res_coeff <= r_coeff;
                r_res_rad   <= RAD_OUT_W'(r_rad);
                r_res_xout  <= XOUT_W'(r_xq);
                r_res_xin   <= XIN_W'(r_xrem);
            end
        end
    end

    assign o_coeff_out       = r_res_coeff;
    assign o_radicand_out    = r_res_rad;
    assign o_x_power_outside = r_res_xout;
    assign o_x_power_inside  = r_res_xin;
    assign o_index_invalid   = r_res_invalid;

    `RS_ASSERT_NXT(a_pow_saturates, i_clk, i_rst_n, i_cmd.pow_step, r_p <= CAP, "power above cap")
    `RS_ASSERT_NXT(a_invalid_zero, i_clk, i_rst_n, i_cmd.out_load && w_invalid, r_res_coeff == '0 && r_res_xin == '0, "invalid result not cleared")
    `RS_ASSERT_NXT(a_rad_shrinks, i_clk, i_rst_n, i_cmd.apply && w_rem_zero, r_rad < $past(r_rad), "radicand did not shrink")

endmodule

### design/rs_ctrl.sv
// Controller: sequences the exponent division, power, trial division and result hand-off.
`include "radical_simplifier_defines.svh"

module rs_ctrl
    import rs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    input  t_rs_status i_st,
    output t_rs_cmd    o_cmd
);

    t_rs_state r_state;
    t_rs_state n_state;
    logic      r_out_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_XDIV;
                end
            end
            S_XDIV: begin
                if (i_st.xdiv_last) begin
                    n_state = i_st.invalid ? S_DONE : S_POW;
                end
            end
            S_POW: begin
                if (i_st.pow_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = i_st.p_gt_rad ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_st.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_POW;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands for the datapath; no item is taken while reset is held.
    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = i_rst_n;
                o_cmd.load = i_s_valid && i_rst_n;
            end
            S_XDIV: begin
                o_cmd.xdiv_step = 1'b1;
                o_cmd.pow_init  = i_st.xdiv_last && !i_st.invalid;
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
            end
            S_CMP: begin
                o_cmd.div_init = !i_st.p_gt_rad;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_APPLY: begin
                o_cmd.apply    = 1'b1;
                o_cmd.pow_init = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = !r_out_valid || i_m_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid flag: set on load, cleared when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_valid = r_out_valid;

    `RS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_m_ready, "result overwritten")
    `RS_ASSERT_NXT(a_load_starts, i_clk, i_rst_n, o_cmd.load, r_state == S_XDIV, "item accepted but work not started")
    `RS_ASSERT_IMP(a_apply_after_div, i_clk, i_rst_n, r_state == S_APPLY, $past(r_state) == S_DIV, "apply without division")

endmodule

### design/radical_simplifier.sv
// Top level of the radical simplifier: stream ports, controller and datapath.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: coeff_in, root_index, radicand_in, x_power
//  m_axis   out        tdata: coeff_out, radicand_out, x_power_outside, x_power_inside;
//                      tuser: index_invalid
//
// One item is worked at a time. Its run time is set by the trial loop, which runs once
// per trial (divisors tried plus factors removed); each trial is an idx-step power multiply
// and a RADICAND_BITS-step divider. Reset is synchronous, active low, and empties the block.
// A finished result waits in the output register while the next item is taken in.

module radical_simplifier
    import rs_pkg::*;
#(
    parameter int RADICAND_BITS = 16,
    parameter int MAX_INDEX     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] coeff_in, [20:16] root_index, [36:21] radicand_in, [44:37] x_power, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [23:0] coeff_out, [39:24] radicand_out, [46:40] x_power_outside,
    // [50:47] x_power_inside, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] index_invalid
    output logic [0:0]           m_axis_tuser
);

    localparam int M_USED_W = COEFF_W + RAD_OUT_W + XOUT_W + XIN_W;

    t_rs_cmd    w_cmd;
    t_rs_status w_st;

    logic signed [COEFF_W-1:0] w_coeff_out;
    logic [RAD_OUT_W-1:0]      w_radicand_out;
    logic [XOUT_W-1:0]         w_x_outside;
    logic [XIN_W-1:0]          w_x_inside;
    logic                      w_invalid;

    // Sequencer.
    rs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_st      (w_st),
        .o_cmd     (w_cmd)
    );

    // Arithmetic and result register.
    rs_dpath #(
        .RADICAND_BITS (RADICAND_BITS),
        .MAX_INDEX     (MAX_INDEX)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_st              (w_st),
        .i_coeff_in        (s_axis_tdata[COEFF_IN_W-1:0]),
        .i_root_index      (s_axis_tdata[COEFF_IN_W +: IDX_W]),
        .i_radicand_in     (s_axis_tdata[COEFF_IN_W + IDX_W +: RAD_IN_W]),
        .i_x_power         (s_axis_tdata[COEFF_IN_W + IDX_W + RAD_IN_W +: XP_W]),
        .o_coeff_out       (w_coeff_out),
        .o_radicand_out    (w_radicand_out),
        .o_x_power_outside (w_x_outside),
        .o_x_power_inside  (w_x_inside),
        .o_index_invalid   (w_invalid)
    );

    // Pack the result item.
    assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, w_x_inside, w_x_outside,
                           w_radicand_out, w_coeff_out};
    assign m_axis_tuser = w_invalid;

endmodule
